### design/lcs_pkg.sv
// Shared constants, command codes and interface types of the convolution stream.
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int Y_BITS      = 38;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int ADDR_W      = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
    localparam int TAP_IDX_W   = 6;
    localparam int CMD_W       = 2;
    localparam int CFG_W       = 7;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    // One tap/sample pair entering the multiply-accumulate unit.
    typedef struct packed {
        logic                          valid;
        logic                          first;
        logic                          last;
        logic signed [SAMPLE_BITS-1:0] tap;
        logic signed [SAMPLE_BITS-1:0] smp;
    } mac_in_t;

    typedef struct packed {
        logic                     done;
        logic signed [Y_BITS-1:0] acc;
    } mac_out_t;

endpackage

### design/lcs_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module lcs_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/lcs_mac.sv
// Two-stage multiply-accumulate unit shared by all taps of one output.
`timescale 1ns / 1ps

module lcs_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  lcs_pkg::mac_in_t  mac_in,
    output lcs_pkg::mac_out_t mac_out
);

    logic signed [lcs_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_valid_reg;
    logic                              prod_first_reg;
    logic                              prod_last_reg;
    logic signed [lcs_pkg::Y_BITS-1:0] acc_reg;
    logic                              done_reg;
    logic signed [lcs_pkg::Y_BITS-1:0] prod_ext;

    assign prod_ext = {{(lcs_pkg::Y_BITS - lcs_pkg::PROD_W){prod_reg[lcs_pkg::PROD_W-1]}},
                       prod_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            prod_valid_reg <= mac_in.valid;
            prod_first_reg <= mac_in.first;
            prod_last_reg  <= mac_in.last;
            done_reg       <= prod_valid_reg && prod_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_in.valid) begin
            prod_reg <= mac_in.tap * mac_in.smp;
        end
        // The first product of an output restarts the sum.
        if (prod_valid_reg) begin
            acc_reg <= (prod_first_reg ? '0 : acc_reg) + prod_ext;
        end
    end

    assign mac_out.done = done_reg;
    assign mac_out.acc  = acc_reg;

endmodule

### design/linear_convolution_stream.sv
// Top level: command sequencer, tap and history memories, output register.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_cmd, s_tap_index, s_sample
//   m_       out        m_valid / m_ready    m_y_value, m_last_of_run
//   cfg_     in         cfg_valid/cfg_ready  cfg_taps_used
//
// A load writes one tap if its index is in range. A push makes one write, then
// passes one tap per cycle through the single shared multiply-accumulate unit and the
// read ports of the two memories, then the pipeline drain and the output load.
// A flush of an open run produces the effective length - 1 results, each made alike.
// Reset clears the memories at once through per-entry valid bits; no sweep.
// A result waiting in the output register holds the sequencer at the next
// output load, and s_ready stays low until that load is done.
`timescale 1ns / 1ps

module linear_convolution_stream (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [lcs_pkg::CMD_W-1:0]              s_cmd,
    input  logic [lcs_pkg::TAP_IDX_W-1:0]          s_tap_index,
    input  logic signed [lcs_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [lcs_pkg::Y_BITS-1:0]      m_y_value,
    output logic                                   m_last_of_run,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lcs_pkg::CFG_W-1:0]              cfg_taps_used
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                            state_reg, state_next;
    logic [lcs_pkg::ADDR_W-1:0]        k_reg, k_next;
    logic [lcs_pkg::TAP_CNT_W-1:0]     tail_reg, tail_next;
    logic                              flush_reg, flush_next;
    logic [lcs_pkg::ADDR_W-1:0]        head_reg, head_next;
    logic                              seen_reg, seen_next;
    logic [lcs_pkg::CFG_W-1:0]         taps_used_reg, taps_used_next;
    logic [lcs_pkg::MAX_TAPS-1:0]      tap_vld_reg, tap_vld_next;
    logic [lcs_pkg::MAX_TAPS-1:0]      hist_vld_reg, hist_vld_next;
    logic                              iss_valid_reg, iss_valid_next;
    logic                              iss_first_reg, iss_first_next;
    logic                              iss_last_reg, iss_last_next;
    logic                              tap_ok_reg, tap_ok_next;
    logic                              hist_ok_reg, hist_ok_next;
    logic                              out_valid_reg, out_valid_next;
    logic signed [lcs_pkg::Y_BITS-1:0] out_y_reg, out_y_next;
    logic                              out_last_reg, out_last_next;

    logic [lcs_pkg::TAP_CNT_W-1:0]     taps_eff;
    logic [lcs_pkg::TAP_CNT_W-1:0]     taps_last;
    logic [lcs_pkg::ADDR_W-1:0]        head_inc;
    logic [lcs_pkg::ADDR_W-1:0]        hist_rd_addr;
    logic                              idx_ok;

    logic                              tap_wr_en;
    logic [lcs_pkg::ADDR_W-1:0]        tap_wr_addr;
    logic                              hist_wr_en;
    logic [lcs_pkg::SAMPLE_BITS-1:0]   hist_wr_data;
    logic                              rd_en;
    logic [lcs_pkg::SAMPLE_BITS-1:0]   tap_rd_data;
    logic [lcs_pkg::SAMPLE_BITS-1:0]   hist_rd_data;

    lcs_pkg::mac_in_t                  mac_in;
    lcs_pkg::mac_out_t                 mac_out;

    // A kernel length of zero acts as one, any above the store acts as full.
    always_comb begin
        if (taps_used_reg == '0) begin
            taps_eff = lcs_pkg::TAP_CNT_W'(1);
        end else if (lcs_pkg::TAP_CNT_W'(taps_used_reg) >
                     lcs_pkg::TAP_CNT_W'(lcs_pkg::MAX_TAPS)) begin
            taps_eff = lcs_pkg::TAP_CNT_W'(lcs_pkg::MAX_TAPS);
        end else begin
            taps_eff = lcs_pkg::TAP_CNT_W'(taps_used_reg);
        end
    end

    assign taps_last = taps_eff - lcs_pkg::TAP_CNT_W'(1);
    assign head_inc  = (head_reg == lcs_pkg::ADDR_W'(lcs_pkg::MAX_TAPS - 1)) ?
                       '0 : head_reg + lcs_pkg::ADDR_W'(1);
    assign idx_ok    = (lcs_pkg::TAP_IDX_W + 1)'(s_tap_index) <
                       (lcs_pkg::TAP_IDX_W + 1)'(lcs_pkg::MAX_TAPS);

    // The history is a circular line; tap k pairs with the sample k places back.
    always_comb begin
        if (k_reg > head_reg) begin
            hist_rd_addr = lcs_pkg::ADDR_W'(lcs_pkg::TAP_CNT_W'(head_reg)
                           + lcs_pkg::TAP_CNT_W'(lcs_pkg::MAX_TAPS)
                           - lcs_pkg::TAP_CNT_W'(k_reg));
        end else begin
            hist_rd_addr = head_reg - k_reg;
        end
    end

    assign tap_wr_addr = lcs_pkg::ADDR_W'(s_tap_index);
    assign rd_en       = (state_reg == ST_MAC);

    lcs_ram #(
        .DEPTH (lcs_pkg::MAX_TAPS),
        .WIDTH (lcs_pkg::SAMPLE_BITS),
        .ADDR_W(lcs_pkg::ADDR_W)
    ) u_tap_ram (
        .aclk   (aclk),
        .wr_en  (tap_wr_en),
        .wr_addr(tap_wr_addr),
        .wr_data(s_sample),
        .rd_en  (rd_en),
        .rd_addr(k_reg),
        .rd_data(tap_rd_data)
    );

    lcs_ram #(
        .DEPTH (lcs_pkg::MAX_TAPS),
        .WIDTH (lcs_pkg::SAMPLE_BITS),
        .ADDR_W(lcs_pkg::ADDR_W)
    ) u_hist_ram (
        .aclk   (aclk),
        .wr_en  (hist_wr_en),
        .wr_addr(head_inc),
        .wr_data(hist_wr_data),
        .rd_en  (rd_en),
        .rd_addr(hist_rd_addr),
        .rd_data(hist_rd_data)
    );

    // Entries never written since reset, and history entries since the last flush, read as zero.
    always_comb begin
        mac_in.valid = iss_valid_reg;
        mac_in.first = iss_first_reg;
        mac_in.last  = iss_last_reg;
        mac_in.tap   = tap_ok_reg ? tap_rd_data : '0;
        mac_in.smp   = hist_ok_reg ? hist_rd_data : '0;
    end

    lcs_mac u_mac (
        .aclk   (aclk),
        .aresetn(aresetn),
        .mac_in (mac_in),
        .mac_out(mac_out)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = out_valid_reg;
    assign m_y_value     = out_y_reg;
    assign m_last_of_run = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        tail_next      = tail_reg;
        flush_next     = flush_reg;
        head_next      = head_reg;
        seen_next      = seen_reg;
        taps_used_next = taps_used_reg;
        tap_vld_next   = tap_vld_reg;
        hist_vld_next  = hist_vld_reg;
        iss_valid_next = 1'b0;
        iss_first_next = iss_first_reg;
        iss_last_next  = iss_last_reg;
        tap_ok_next    = tap_ok_reg;
        hist_ok_next   = hist_ok_reg;
        out_valid_next = out_valid_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        tap_wr_en      = 1'b0;
        hist_wr_en     = 1'b0;
        hist_wr_data   = '0;

        if (cfg_valid) begin
            taps_used_next = cfg_taps_used;
        end
        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_cmd)
                        lcs_pkg::CMD_LOAD: begin
                            if (idx_ok) begin
                                tap_wr_en                 = 1'b1;
                                tap_vld_next[tap_wr_addr] = 1'b1;
                            end
                        end
                        lcs_pkg::CMD_PUSH: begin
                            hist_wr_en              = 1'b1;
                            hist_wr_data            = s_sample;
                            hist_vld_next[head_inc] = 1'b1;
                            head_next               = head_inc;
                            seen_next               = 1'b1;
                            flush_next              = 1'b0;
                            k_next                  = '0;
                            state_next              = ST_MAC;
                        end
                        lcs_pkg::CMD_FLUSH: begin
                            if (!seen_reg || taps_eff == lcs_pkg::TAP_CNT_W'(1)) begin
                                hist_vld_next = '0;
                                head_next     = '0;
                                seen_next     = 1'b0;
                            end else begin
                                hist_wr_en              = 1'b1;
                                hist_vld_next[head_inc] = 1'b1;
                                head_next               = head_inc;
                                flush_next              = 1'b1;
                                tail_next               = lcs_pkg::TAP_CNT_W'(1);
                                k_next                  = '0;
                                state_next              = ST_MAC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                // Each tail output shifts one zero into the history.
                hist_wr_en              = 1'b1;
                hist_vld_next[head_inc] = 1'b1;
                head_next               = head_inc;
                k_next                  = '0;
                state_next              = ST_MAC;
            end
            ST_MAC: begin
                iss_valid_next = 1'b1;
                iss_first_next = (k_reg == '0);
                iss_last_next  = (lcs_pkg::TAP_CNT_W'(k_reg) == taps_last);
                tap_ok_next    = tap_vld_reg[k_reg];
                hist_ok_next   = hist_vld_reg[hist_rd_addr];
                if (lcs_pkg::TAP_CNT_W'(k_reg) == taps_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + lcs_pkg::ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                if (mac_out.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_y_next     = mac_out.acc;
                    out_last_next  = !flush_reg || (tail_reg == taps_last);
                    if (flush_reg && tail_reg != taps_last) begin
                        tail_next  = tail_reg + lcs_pkg::TAP_CNT_W'(1);
                        state_next = ST_SHIFT;
                    end else begin
                        if (flush_reg) begin
                            hist_vld_next = '0;
                            head_next     = '0;
                            seen_next     = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            tail_reg      <= '0;
            flush_reg     <= 1'b0;
            head_reg      <= '0;
            seen_reg      <= 1'b0;
            taps_used_reg <= lcs_pkg::CFG_W'(1);
            tap_vld_reg   <= '0;
            hist_vld_reg  <= '0;
            iss_valid_reg <= 1'b0;
            iss_first_reg <= 1'b0;
            iss_last_reg  <= 1'b0;
            tap_ok_reg    <= 1'b0;
            hist_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            tail_reg      <= tail_next;
            flush_reg     <= flush_next;
            head_reg      <= head_next;
            seen_reg      <= seen_next;
            taps_used_reg <= taps_used_next;
            tap_vld_reg   <= tap_vld_next;
            hist_vld_reg  <= hist_vld_next;
            iss_valid_reg <= iss_valid_next;
            iss_first_reg <= iss_first_next;
            iss_last_reg  <= iss_last_next;
            tap_ok_reg    <= tap_ok_next;
            hist_ok_reg   <= hist_ok_next;
            out_valid_reg <= out_valid_next;
            out_y_reg     <= out_y_next;
            out_last_reg  <= out_last_next;
        end
    end

    // No tap product may still be in flight once a new item can be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !iss_valid_reg && !mac_out.done)
        else $error("MAC pipeline busy while accepting an item");

    // A finished sum only appears while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mac_out.done |-> state_reg == ST_DRAIN)
        else $error("MAC result outside drain state");

    // A push always leaves the run marked as started.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == lcs_pkg::CMD_PUSH) |=> seen_reg)
        else $error("push did not mark the run as started");

    // The head pointer stays within the history line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        lcs_pkg::TAP_CNT_W'(head_reg) < lcs_pkg::TAP_CNT_W'(lcs_pkg::MAX_TAPS))
        else $error("history head out of range");

endmodule

### tb/sv/tb_linear_convolution_stream.sv
// Self-checking testbench for the streamed linear convolution block.
`timescale 1ns / 1ps

module tb_linear_convolution_stream;
    import lcs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_GAP   = 150;
    localparam int LONG_HOLD  = 400;
    localparam int RAND_ITEMS = 270;

    typedef struct {
        logic signed [Y_BITS-1:0] y_value;
        logic                     last_of_run;
    } conv_out_t;

    // Holds a private copy of the kernel, the sample history and the length
    // register, and keeps the outputs owed by the block in order.
    class conv_scoreboard;
        logic signed [SAMPLE_BITS-1:0] kernel [MAX_TAPS];
        logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
        logic [ADDR_W-1:0]             newest;
        bit                            run_open;
        logic [CFG_W-1:0]              taps_reg;
        conv_out_t                     expected_q [$];
        int                            errors;
        int                            checked;
        int                            accepted;

        function new();
            foreach (kernel[i]) kernel[i] = '0;
            clear_history();
            taps_reg = 7'd1;
            errors   = 0;
            checked  = 0;
            accepted = 0;
        endfunction

        function void clear_history();
            foreach (history[i]) history[i] = '0;
            newest   = '0;
            run_open = 1'b0;
        endfunction

        function int active_taps();
            if (taps_reg == 0) return 1;
            if (taps_reg > MAX_TAPS) return MAX_TAPS;
            return int'(taps_reg);
        endfunction

        // Shifts one sample into the history and returns the exact output sum.
        function logic signed [Y_BITS-1:0] shift_in(logic signed [SAMPLE_BITS-1:0] x);
            longint            acc;
            logic [ADDR_W-1:0] pos;
            acc = 0;
            newest = newest + 1'b1;
            history[newest] = x;
            for (int k = 0; k < active_taps(); k++) begin
                pos = newest - ADDR_W'(k);
                acc += longint'(kernel[k]) * longint'(history[pos]);
            end
            return acc[Y_BITS-1:0];
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [TAP_IDX_W-1:0] idx,
                                logic signed [SAMPLE_BITS-1:0] smp);
            int        taps;
            conv_out_t r;
            accepted++;
            taps = active_taps();
            case (cmd)
                CMD_LOAD: kernel[idx] = smp;
                CMD_PUSH: begin
                    run_open      = 1'b1;
                    r.y_value     = shift_in(smp);
                    r.last_of_run = 1'b1;
                    expected_q.push_back(r);
                end
                CMD_FLUSH: begin
                    // The tail is the output of taps-1 zero samples.
                    if (run_open) begin
                        for (int j = 1; j < taps; j++) begin
                            r.y_value     = shift_in('0);
                            r.last_of_run = (j + 1 == taps);
                            expected_q.push_back(r);
                        end
                        clear_history();
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [Y_BITS-1:0] y, logic last);
            conv_out_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: y_value %0d, last_of_run %0b", y, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (y !== want.y_value) begin
                $error("y_value: expected %0d, actual %0d", want.y_value, y);
                errors++;
            end
            if (last !== want.last_of_run) begin
                $error("last_of_run: expected %0b, actual %0b", want.last_of_run, last);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [CMD_W-1:0]              s_cmd;
    logic [TAP_IDX_W-1:0]          s_tap_index;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [Y_BITS-1:0]      m_y_value;
    logic                          m_last_of_run;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_W-1:0]              cfg_taps_used;

    logic           hold_request;
    bit             hold_served;
    int             burst_left;
    int             settings_used;
    conv_scoreboard sb = new();

    linear_convolution_stream uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_tap_index   (s_tap_index),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_y_value     (m_y_value),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_taps_used (cfg_taps_used)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_y_value, m_last_of_run);
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Mostly aims loads at taps that are in use.
    function automatic logic [TAP_IDX_W-1:0] pick_index(input int taps);
        if ($urandom_range(0, 9) < 7) return TAP_IDX_W'($urandom_range(0, taps - 1));
        return TAP_IDX_W'($urandom);
    endfunction

    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [TAP_IDX_W-1:0] idx,
                         input logic signed [SAMPLE_BITS-1:0] smp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_tap_index <= idx;
        s_sample    <= smp;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(cmd, idx, smp);
    endtask

    task automatic settle();
        s_valid   <= 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        // A trailing load or empty flush may still be in flight.
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic write_taps(input logic [CFG_W-1:0] value);
        cfg_valid     <= 1'b1;
        cfg_taps_used <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.taps_reg = value;
        settings_used++;
    endtask

    task automatic run_random(input int count);
        int taps;
        int n_load;
        int n_push;
        int done;
        done = 0;
        while (done < count) begin
            taps = sb.active_taps();
            if ($urandom_range(0, 4) != 0) begin
                n_load = $urandom_range(0, 4);
                n_push = $urandom_range(1, 10);
                repeat (n_load) offer(CMD_LOAD, pick_index(taps), pick_sample());
                repeat (n_push) begin
                    // Now and then a tap is rewritten in the middle of a run.
                    if ($urandom_range(0, 7) == 0) begin
                        offer(CMD_LOAD, pick_index(taps), pick_sample());
                        done++;
                    end
                    offer(CMD_PUSH, TAP_IDX_W'($urandom), pick_sample());
                end
                done += n_load + n_push;
                if ($urandom_range(0, 3) != 0) begin
                    offer(CMD_FLUSH, TAP_IDX_W'($urandom), SAMPLE_BITS'($urandom));
                    done++;
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        offer(CMD_UNUSED, TAP_IDX_W'($urandom), SAMPLE_BITS'($urandom));
                        done++;
                    end
                    1: begin
                        offer(CMD_FLUSH, TAP_IDX_W'($urandom), SAMPLE_BITS'($urandom));
                        done++;
                    end
                    default: begin
                        offer(CMD_PUSH, TAP_IDX_W'($urandom), pick_sample());
                        done++;
                    end
                endcase
            end
        end
    endtask

    initial begin : receiver
        int         span;
        int         mode;
        logic [7:0] pattern;
        span    = 0;
        mode    = 0;
        pattern = '1;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (span == 0) begin
                mode    = $urandom_range(0, 3);
                span    = $urandom_range(8, 64);
                pattern = 8'($urandom);
            end
            span--;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= pattern[span % 8];
                default: m_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] lengths [9];
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_cmd         <= CMD_LOAD;
        s_tap_index   <= '0;
        s_sample      <= '0;
        cfg_valid     <= 1'b0;
        cfg_taps_used <= '0;
        hold_request  <= 1'b0;
        hold_served    = 1'b0;
        burst_left     = 0;
        settings_used  = 0;
        lengths = '{7'd3, 7'd64, 7'd8, 7'd1, 7'd127, 7'd0, 7'd2, 7'd16, 7'd0};
        lengths[8] = CFG_W'($urandom_range(1, 12));
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Out of reset the kernel is one zero tap and no run is open.
        offer(CMD_FLUSH, '0, '0);
        offer(CMD_UNUSED, '1, 16'sh7FFF);
        offer(CMD_PUSH, '0, 16'sh7FFF);
        offer(CMD_LOAD, '0, 16'sh8000);
        offer(CMD_PUSH, '1, 16'sh8000);
        offer(CMD_FLUSH, '0, '0);
        settle();

        // A length of zero behaves as a single tap.
        write_taps(7'd0);
        offer(CMD_PUSH, '0, 16'sh1234);
        offer(CMD_LOAD, 6'd63, 16'sh7FFF);
        offer(CMD_FLUSH, '0, '0);
        settle();

        // A length above the store size is clipped, so the top tap is used.
        write_taps(7'd127);
        offer(CMD_LOAD, 6'd1, 16'sh7FFF);
        offer(CMD_PUSH, '0, 16'sh8000);
        offer(CMD_PUSH, '0, 16'sh7FFF);
        offer(CMD_FLUSH, '0, '0);
        settle();

        // Shrink the kernel while a run is still open.
        write_taps(7'd4);
        offer(CMD_LOAD, 6'd2, 16'sh8000);
        offer(CMD_PUSH, '0, 16'sh8000);
        offer(CMD_PUSH, '0, 16'sh7FFF);
        offer(CMD_PUSH, '0, 16'sh8000);
        settle();
        write_taps(7'd2);
        offer(CMD_PUSH, '0, 16'sh0001);
        offer(CMD_FLUSH, '0, '0);
        offer(CMD_FLUSH, '0, '0);

        foreach (lengths[i]) begin
            settle();
            write_taps(lengths[i]);
            if (i == 0) hold_request <= 1'b1;
            run_random(RAND_ITEMS / 9);
        end
        settle();

        $display("Covered %0d accepted items and %0d checked results", sb.accepted, sb.checked);
        $display("over %0d kernel length settings, including 0, 1, 64 and 127.",
                 settings_used);
        if (sb.errors == 0) begin
            $display("tb_linear_convolution_stream: PASS");
        end else begin
            $display("tb_linear_convolution_stream: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #200_000_000;
        $display("Timeout with %0d results still owed.", sb.expected_q.size());
        $display("tb_linear_convolution_stream: FAIL");
        $finish;
    end

endmodule
